// ===== rtl/core/btp_pkg.sv =====
`default_nettype none
package btp_pkg;

	localparam int CUBE_EDGE    = 16;
	localparam int TAPER_LAYERS = 4;

	localparam int NUM_FACES  = 6;
	localparam int FACE_W     = 3;
	localparam int CW         = $clog2(CUBE_EDGE);
	localparam int PLANE_SIZE = CUBE_EDGE * CUBE_EDGE;
	localparam int PLANE_AW   = $clog2(PLANE_SIZE);

	localparam int ERR_W   = 24;
	localparam int SMP_W   = 16;
	localparam int STR_W   = 16;
	localparam int TAPER_W = 13;
	localparam int COEF_W  = STR_W + TAPER_W;
	localparam int PROD_W  = COEF_W + ERR_W;
	localparam int FRAC_W  = 32;
	localparam int ACC_W   = 58;
	localparam int STEP_W  = 3;

	localparam int REG_IDX_W = 1;
	localparam int REG_DAT_W = 16;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_VOXEL = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STRENGTH    = 1'd0,
		REG_SAMPLE_MODE = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic              write_entry;
		logic              start;
		logic              load_voxel;
		logic              issue;
		logic [FACE_W-1:0] face;
		logic              finish;
	} ctrl_cmd_t;

	function automatic logic [TAPER_W-1:0] taper_coef(input logic [1:0] depth);
		logic [TAPER_W-1:0] c;
		case (depth)
			2'd0:    c = TAPER_W'(4096);
			2'd1:    c = TAPER_W'(2867);
			2'd2:    c = TAPER_W'(1638);
			default: c = TAPER_W'(737);
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/btp_in_if.sv =====
`default_nettype none
interface btp_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          command;
	logic [btp_pkg::FACE_W-1:0]          face;
	logic [5:0]                          plane_row;
	logic [5:0]                          plane_col;
	logic signed [btp_pkg::ERR_W-1:0]    error_value;
	logic [btp_pkg::SMP_W-1:0]           voxel_value;

	modport source (
		output valid, command, face, plane_row, plane_col, error_value, voxel_value,
		input  ready
	);
	modport sink (
		input  valid, command, face, plane_row, plane_col, error_value, voxel_value,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/btp_out_if.sv =====
`default_nettype none
interface btp_out_if;
	logic                      valid;
	logic                      ready;
	logic [btp_pkg::SMP_W-1:0] out_value;
	logic                      last_voxel;

	modport source (
		output valid, out_value, last_voxel,
		input  ready
	);
	modport sink (
		input  valid, out_value, last_voxel,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/btp_ctrl.sv =====
`default_nettype none
module btp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        in_command,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output btp_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MAC  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	localparam logic [btp_pkg::STEP_W-1:0] STEP_LAST = btp_pkg::STEP_W'(btp_pkg::NUM_FACES + 1);

	state_t                      state_q;
	logic [btp_pkg::STEP_W-1:0]  step_q;
	logic                        out_valid_q;
	logic                        accept;
	logic                        finish;
	btp_pkg::cmd_t               code;

	assign code     = btp_pkg::cmd_t'(in_command);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign finish   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (code)
				btp_pkg::CMD_WRITE: cmd.write_entry = 1'b1;
				btp_pkg::CMD_VOXEL: cmd.load_voxel  = 1'b1;
				btp_pkg::CMD_START: cmd.start       = 1'b1;
				default:            cmd = '0;
			endcase
		end
		cmd.issue  = (state_q == ST_MAC) && (step_q < btp_pkg::STEP_W'(btp_pkg::NUM_FACES));
		cmd.face   = btp_pkg::FACE_W'(step_q);
		cmd.finish = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (cmd.load_voxel)
						state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (step_q == STEP_LAST)
						state_q <= ST_DONE;
					else
						step_q <= step_q + 1'b1;
				end
				ST_DONE: begin
					if (finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/btp_datapath.sv =====
`default_nettype none
module btp_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire btp_pkg::ctrl_cmd_t                cmd,
	input  wire logic [btp_pkg::FACE_W-1:0]        face,
	input  wire logic [5:0]                        plane_row,
	input  wire logic [5:0]                        plane_col,
	input  wire logic signed [btp_pkg::ERR_W-1:0]  error_value,
	input  wire logic [btp_pkg::SMP_W-1:0]         voxel_value,
	input  wire logic                              wr_en,
	input  wire logic [btp_pkg::REG_IDX_W-1:0]     wr_index,
	input  wire logic [btp_pkg::REG_DAT_W-1:0]     wr_data,
	output logic [btp_pkg::SMP_W-1:0]              out_value,
	output logic                                   last_voxel
);

	localparam int CW  = btp_pkg::CW;
	localparam int AW  = btp_pkg::PLANE_AW;
	localparam int NF  = btp_pkg::NUM_FACES;
	localparam logic [CW-1:0] TOP = CW'(btp_pkg::CUBE_EDGE - 1);
	localparam int HI_W = btp_pkg::ACC_W - btp_pkg::FRAC_W;

	logic signed [btp_pkg::ERR_W-1:0] plane_mem [NF][btp_pkg::PLANE_SIZE];
	logic signed [btp_pkg::ERR_W-1:0] rd_q [NF];
	logic [AW-1:0]                    raddr [NF];
	logic [AW-1:0]                    waddr;
	logic                             wr_ok;

	logic [btp_pkg::STR_W-1:0] strength_q;
	logic                      mode_q;
	logic [NF-1:0]             present_q;
	logic [CW-1:0]             x_q, y_q, z_q;

	logic [CW-1:0]                    depth;
	logic                             term_en;
	logic                             v_s1, v_s2;
	logic [btp_pkg::COEF_W-1:0]       k_s1;
	logic signed [btp_pkg::ERR_W-1:0] e_s1;
	logic signed [btp_pkg::PROD_W-1:0] prod_s2;
	logic signed [btp_pkg::ACC_W-1:0] acc_q;

	logic [HI_W-1:0]             whole;
	logic [btp_pkg::SMP_W-1:0]   sat_hi;
	logic [btp_pkg::SMP_W-1:0]   result;
	logic [btp_pkg::SMP_W-1:0]   out_value_q;
	logic                        last_q;

	assign waddr = AW'(13'(plane_row) * 13'(btp_pkg::CUBE_EDGE) + 13'(plane_col));
	assign wr_ok = (face < btp_pkg::FACE_W'(NF))
		&& (7'(plane_row) < 7'(btp_pkg::CUBE_EDGE))
		&& (7'(plane_col) < 7'(btp_pkg::CUBE_EDGE));

	always_comb begin
		raddr[0] = AW'(AW'(z_q) * AW'(btp_pkg::CUBE_EDGE) + AW'(y_q));
		raddr[1] = raddr[0];
		raddr[2] = AW'(AW'(z_q) * AW'(btp_pkg::CUBE_EDGE) + AW'(x_q));
		raddr[3] = raddr[2];
		raddr[4] = AW'(AW'(y_q) * AW'(btp_pkg::CUBE_EDGE) + AW'(x_q));
		raddr[5] = raddr[4];
	end

	always_ff @(posedge clk) begin
		for (int f = 0; f < NF; f++) begin
			if (cmd.write_entry && wr_ok && face == btp_pkg::FACE_W'(f))
				plane_mem[f][waddr] <= error_value;
			if (cmd.load_voxel)
				rd_q[f] <= plane_mem[f][raddr[f]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= '0;
			mode_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (btp_pkg::reg_idx_t'(wr_index))
				btp_pkg::REG_STRENGTH:    strength_q <= wr_data;
				btp_pkg::REG_SAMPLE_MODE: mode_q     <= wr_data[0];
				default:                  mode_q     <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
		end else begin
			if (cmd.start) begin
				present_q <= '0;
				x_q       <= '0;
				y_q       <= '0;
				z_q       <= '0;
			end else begin
				if (cmd.write_entry && wr_ok)
					present_q <= present_q | (NF'(1) << face);
				if (cmd.finish) begin
					if (x_q == TOP) begin
						x_q <= '0;
						if (y_q == TOP) begin
							y_q <= '0;
							z_q <= (z_q == TOP) ? '0 : z_q + 1'b1;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		case (cmd.face)
			3'd0:    depth = x_q;
			3'd1:    depth = TOP - x_q;
			3'd2:    depth = y_q;
			3'd3:    depth = TOP - y_q;
			3'd4:    depth = z_q;
			3'd5:    depth = TOP - z_q;
			default: depth = x_q;
		endcase
		term_en = (cmd.face < btp_pkg::FACE_W'(NF)) && present_q[cmd.face]
			&& ({1'b0, depth} < (CW+1)'(btp_pkg::TAPER_LAYERS));
	end

	// term pipeline: coefficient, product, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			k_s1 <= term_en
				? btp_pkg::COEF_W'(strength_q) * btp_pkg::COEF_W'(btp_pkg::taper_coef(depth[1:0]))
				: '0;
			e_s1 <= rd_q[cmd.face];
		end
		prod_s2 <= btp_pkg::PROD_W'($signed(k_s1)) * btp_pkg::PROD_W'(e_s1);
		if (cmd.load_voxel)
			acc_q <= $signed({(HI_W - btp_pkg::SMP_W)'(0), voxel_value, 32'h8000_0000});
		else if (v_s2)
			acc_q <= acc_q + btp_pkg::ACC_W'(prod_s2);
	end

	always_comb begin
		whole  = acc_q[btp_pkg::ACC_W-1:btp_pkg::FRAC_W];
		sat_hi = mode_q ? 16'hFFFF : 16'h00FF;
		if (acc_q[btp_pkg::ACC_W-1])
			result = '0;
		else if (whole > HI_W'(sat_hi))
			result = sat_hi;
		else
			result = whole[btp_pkg::SMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_value_q <= result;
			last_q      <= (x_q == TOP) && (y_q == TOP) && (z_q == TOP);
		end
	end

	assign out_value  = out_value_q;
	assign last_voxel = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/boundary_taper_preconditioner_top.sv =====
// channel   dir  handshake     payload
// item      in   valid/ready   command, face, plane_row, plane_col, error_value, voxel_value
// result    out  valid/ready   out_value, last_voxel
// wr_*      in   wr_en only    wr_index, wr_data
//
// Write, start and ignored requests finish as soon as they are accepted. A voxel
// request runs one banked plane read, six face terms through one shared
// coefficient/multiply/accumulate pipe and a round/clamp step, taking no new
// request until done. A finished result waits in the output register while the
// next request is taken; a voxel stalls at its end only while that register is
// full and not taken. Reset clears control state, strength/mode, flags and position.
`default_nettype none
module boundary_taper_preconditioner_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	btp_in_if.sink                              item,
	btp_out_if.source                           result,
	input  wire logic                           wr_en,
	input  wire logic [btp_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [btp_pkg::REG_DAT_W-1:0]  wr_data
);

	btp_pkg::ctrl_cmd_t cmd;

	btp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_command (item.command),
		.in_ready   (item.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.cmd        (cmd)
	);

	btp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.face        (item.face),
		.plane_row   (item.plane_row),
		.plane_col   (item.plane_col),
		.error_value (item.error_value),
		.voxel_value (item.voxel_value),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.out_value   (result.out_value),
		.last_voxel  (result.last_voxel)
	);

endmodule
`default_nettype wire
